// File: rtl/ptfb_pkg.sv
// ----------------------------------------------------------------------------
// ptfb_pkg
// Shared types, constants and helper functions for the per-thread FIFO bank.
// ----------------------------------------------------------------------------
package ptfb_pkg;

    // Default sizing of the bank
    localparam int NUM_QUEUES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int DATA_WIDTH_DEF  = 32;

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int THREAD_W = 16;
    localparam int VALUE_W  = 32;
    localparam int CFG_W    = 4;

    // Active queue count after reset
    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(8);

    // Modulo unit works on one thread-id digit of CFG_W bits per cycle
    localparam int DIGITS = THREAD_W / CFG_W;

    // Entries of the job queue between front and back
    localparam int JOBQ_DEPTH = 2;

    // Request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT    = 2'd0,
        CMD_REMOVE    = 2'd1,
        CMD_QUERY_Q   = 2'd2,
        CMD_QUERY_ALL = 2'd3
    } t_cmd;

    // Index width for an array of n entries (at least one bit)
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Width of a counter that holds 0..n
    function automatic int cnt_w(input int n);
        return $clog2(n + 1);
    endfunction

    // Number of queues really in use: zero acts as one, saturate at nq
    function automatic logic [CFG_W-1:0] eff_count(input logic [CFG_W-1:0] a,
                                                   input int nq);
        if (a == '0) begin
            return CFG_W'(1);
        end
        if (int'(a) > nq) begin
            return CFG_W'(nq);
        end
        return a;
    endfunction

endpackage

// File: rtl/ptfb_ram.sv
// ----------------------------------------------------------------------------
// ptfb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ptfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [ptfb_pkg::idx_w(DEPTH)-1:0]    i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [ptfb_pkg::idx_w(DEPTH)-1:0]    i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    import ptfb_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds when idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ptfb_front.sv
// ----------------------------------------------------------------------------
// ptfb_front
// Request front end: accepts a transaction, reduces the thread id modulo the
// active queue count one digit per cycle, then hands a job to the job queue.
// ----------------------------------------------------------------------------
module ptfb_front #(
    parameter int NUM_QUEUES = ptfb_pkg::NUM_QUEUES_DEF,
    parameter int DATA_WIDTH = ptfb_pkg::DATA_WIDTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // request channel
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic [ptfb_pkg::CMD_W-1:0]               i_command,
    input  logic [ptfb_pkg::THREAD_W-1:0]            i_thread_id,
    input  logic [ptfb_pkg::VALUE_W-1:0]             i_item_value,
    // active queue count
    input  logic [ptfb_pkg::CFG_W-1:0]               i_eff,
    // job output
    output logic                                     o_push,
    input  logic                                     i_full,
    output ptfb_pkg::t_cmd                           o_cmd,
    output logic [ptfb_pkg::idx_w(NUM_QUEUES)-1:0]   o_q,
    output logic [DATA_WIDTH-1:0]                    o_value
);
    import ptfb_pkg::*;

    localparam int QIW   = idx_w(NUM_QUEUES);
    localparam int DIG_W = idx_w(DIGITS);
    localparam int XW    = 2 * CFG_W;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate                r_state, n_state;
    logic [DIG_W-1:0]       r_dig,   n_dig;
    logic [THREAD_W-1:0]    r_tid,   n_tid;
    logic [CFG_W-1:0]       r_rem,   n_rem;
    t_cmd                   r_cmd,   n_cmd;
    logic [DATA_WIDTH-1:0]  r_val,   n_val;

    logic                   accept;
    logic [XW-1:0]          x;

    // Stall: free when idle, or when the finished job leaves this cycle
    always_comb begin
        case (r_state)
            F_IDLE:  o_in_stall = 1'b0;
            F_PUSH:  o_in_stall = i_full;
            default: o_in_stall = 1'b1;
        endcase
    end

    assign accept = i_in_valid && !o_in_stall;

    // One modulo digit: restoring reduction of {rem, digit} by the count
    always_comb begin
        x = {r_rem, r_tid[THREAD_W-1 -: CFG_W]};
        for (int k = CFG_W - 1; k >= 0; k--) begin
            if (x >= (XW'(i_eff) << k)) begin
                x = x - (XW'(i_eff) << k);
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_dig   = r_dig;
        n_tid   = r_tid;
        n_rem   = r_rem;
        n_cmd   = r_cmd;
        n_val   = r_val;
        case (r_state)
            F_IDLE: begin
            end
            F_DIV: begin
                n_rem = x[CFG_W-1:0];
                n_tid = r_tid << CFG_W;
                if (r_dig == DIG_W'(DIGITS - 1)) begin
                    n_state = F_PUSH;
                end else begin
                    n_dig = r_dig + 1'b1;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
        if (accept) begin
            n_cmd   = t_cmd'(i_command);
            n_val   = DATA_WIDTH'(i_item_value);
            n_tid   = i_thread_id;
            n_rem   = '0;
            n_dig   = '0;
            n_state = F_DIV;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_dig   <= '0;
        end else begin
            r_state <= n_state;
            r_dig   <= n_dig;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_tid <= n_tid;
        r_rem <= n_rem;
        r_cmd <= n_cmd;
        r_val <= n_val;
    end

    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_cmd   = r_cmd;
    assign o_q     = QIW'(r_rem);
    assign o_value = r_val;

endmodule

// File: rtl/ptfb_queue.sv
// ----------------------------------------------------------------------------
// ptfb_queue
// Short register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ptfb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ptfb_pkg::JOBQ_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output logic [WIDTH-1:0]  o_data
);
    import ptfb_pkg::*;

    localparam int PTW = idx_w(DEPTH);
    localparam int CNW = cnt_w(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTW-1:0]   r_wr, r_rd;
    logic [CNW-1:0]   r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/ptfb_back.sv
// ----------------------------------------------------------------------------
// ptfb_back
// Execution back end: per-queue pointer/count read-modify-write, entry
// memory access, running total, count sweep after a reconfiguration, and
// the result output register.
// ----------------------------------------------------------------------------
module ptfb_back #(
    parameter int NUM_QUEUES  = ptfb_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = ptfb_pkg::QUEUE_DEPTH_DEF,
    parameter int DATA_WIDTH  = ptfb_pkg::DATA_WIDTH_DEF
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic [ptfb_pkg::CFG_W-1:0]                            i_eff,
    input  logic                                                  i_sweep_start,
    // job input
    input  logic                                                  i_job_valid,
    output logic                                                  o_job_pop,
    input  ptfb_pkg::t_cmd                                        i_job_cmd,
    input  logic [ptfb_pkg::idx_w(NUM_QUEUES)-1:0]                i_job_q,
    input  logic [DATA_WIDTH-1:0]                                 i_job_value,
    // result channel
    output logic                                                  o_out_valid,
    input  logic                                                  i_out_stall,
    output logic [ptfb_pkg::VALUE_W-1:0]                          o_removed_value,
    output logic                                                  o_value_valid,
    output logic                                                  o_insert_dropped,
    output logic [ptfb_pkg::cnt_w(QUEUE_DEPTH)-1:0]               o_queue_items,
    output logic                                                  o_queue_is_empty,
    output logic [ptfb_pkg::cnt_w(NUM_QUEUES*QUEUE_DEPTH)-1:0]    o_total_items,
    output logic                                                  o_all_are_empty
);
    import ptfb_pkg::*;

    localparam int QIW = idx_w(NUM_QUEUES);
    localparam int PW  = idx_w(QUEUE_DEPTH);
    localparam int CW  = cnt_w(QUEUE_DEPTH);
    localparam int ED  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int TW  = cnt_w(ED);
    localparam int AW  = idx_w(ED);
    localparam int SW  = 2 * PW + CW;
    localparam logic [PW:0] DEPTH_P = (PW + 1)'(QUEUE_DEPTH);

    // Per-queue bookkeeping word
    typedef struct packed {
        logic [PW-1:0] rp;
        logic [PW-1:0] wp;
        logic [CW-1:0] occ;
    } t_qstate;

    typedef enum logic [4:0] {
        B_IDLE   = 5'b00001,
        B_EXEC   = 5'b00010,
        B_DONE   = 5'b00100,
        B_SW_RD  = 5'b01000,
        B_SW_ACC = 5'b10000
    } t_bstate;

    // Entry address of pointer p in queue q
    function automatic logic [AW-1:0] entry_addr(input logic [QIW-1:0] q,
                                                 input logic [PW-1:0]  p);
        return AW'(q) * AW'(QUEUE_DEPTH) + AW'(p);
    endfunction

    // Circular pointer advance
    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        logic [PW:0] s;
        s = {1'b0, p} + 1'b1;
        return (s >= DEPTH_P) ? '0 : s[PW-1:0];
    endfunction

    // Control state
    t_bstate               r_state,     n_state;
    logic                  r_sweep_pend, n_sweep_pend;
    logic [NUM_QUEUES-1:0] r_st_vld,    n_st_vld;
    logic                  r_rd_vld,    n_rd_vld;
    logic [QIW-1:0]        r_idx,       n_idx;
    logic [TW-1:0]         r_acc,       n_acc;
    logic [TW-1:0]         r_total,     n_total;
    logic                  r_out_valid, n_out_valid;

    // Job and result payload
    t_cmd                  r_cmd,       n_cmd;
    logic [QIW-1:0]        r_q,         n_q;
    logic [DATA_WIDTH-1:0] r_val,       n_val;
    logic [CW-1:0]         r_res_occ,   n_res_occ;
    logic                  r_res_rm,    n_res_rm;
    logic                  r_res_drop,  n_res_drop;
    logic [VALUE_W-1:0]    r_out_removed, n_out_removed;
    logic                  r_out_vvalid,  n_out_vvalid;
    logic                  r_out_drop,    n_out_drop;
    logic [CW-1:0]         r_out_qitems,  n_out_qitems;
    logic                  r_out_qempty,  n_out_qempty;
    logic [TW-1:0]         r_out_total,   n_out_total;
    logic                  r_out_allempty, n_out_allempty;

    // Memory ports
    logic                  st_we, st_re;
    logic [QIW-1:0]        st_waddr, st_raddr;
    logic [SW-1:0]         st_wdata, st_rdata;
    logic                  en_we, en_re;
    logic [AW-1:0]         en_waddr, en_raddr;
    logic [DATA_WIDTH-1:0] en_wdata, en_rdata;

    t_qstate               cur, nxt;
    logic [TW-1:0]         sum;

    // Per-queue pointers and counts
    ptfb_ram #(
        .WIDTH (SW),
        .DEPTH (NUM_QUEUES)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // Queue entries, QUEUE_DEPTH words per queue
    ptfb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (ED)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (en_we),
        .i_waddr (en_waddr),
        .i_wdata (en_wdata),
        .i_re    (en_re),
        .i_raddr (en_raddr),
        .o_rdata (en_rdata)
    );

    // A queue never written since reset reads as empty
    assign cur = r_rd_vld ? t_qstate'(st_rdata) : '0;
    assign sum = r_acc + TW'(cur.occ);

    // Sequencer
    always_comb begin
        n_state        = r_state;
        n_sweep_pend   = r_sweep_pend;
        n_st_vld       = r_st_vld;
        n_rd_vld       = r_rd_vld;
        n_idx          = r_idx;
        n_acc          = r_acc;
        n_total        = r_total;
        n_out_valid    = r_out_valid;
        n_cmd          = r_cmd;
        n_q            = r_q;
        n_val          = r_val;
        n_res_occ      = r_res_occ;
        n_res_rm       = r_res_rm;
        n_res_drop     = r_res_drop;
        n_out_removed  = r_out_removed;
        n_out_vvalid   = r_out_vvalid;
        n_out_drop     = r_out_drop;
        n_out_qitems   = r_out_qitems;
        n_out_qempty   = r_out_qempty;
        n_out_total    = r_out_total;
        n_out_allempty = r_out_allempty;

        o_job_pop = 1'b0;
        st_re     = 1'b0;
        st_raddr  = i_job_q;
        st_we     = 1'b0;
        st_waddr  = r_q;
        nxt       = cur;
        en_we     = 1'b0;
        en_waddr  = entry_addr(r_q, cur.wp);
        en_wdata  = r_val;
        en_re     = 1'b0;
        en_raddr  = entry_addr(r_q, cur.rp);

        // Result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            B_IDLE: begin
                if (r_sweep_pend) begin
                    n_sweep_pend = 1'b0;
                    n_idx        = '0;
                    n_acc        = '0;
                    n_state      = B_SW_RD;
                end else if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_cmd     = i_job_cmd;
                    n_q       = i_job_q;
                    n_val     = i_job_value;
                    st_re     = 1'b1;
                    st_raddr  = i_job_q;
                    n_rd_vld  = r_st_vld[i_job_q];
                    n_state   = B_EXEC;
                end
            end
            B_EXEC: begin
                n_res_rm   = 1'b0;
                n_res_drop = 1'b0;
                case (r_cmd)
                    CMD_INSERT: begin
                        if (cur.occ == CW'(QUEUE_DEPTH)) begin
                            n_res_drop = 1'b1;
                        end else begin
                            en_we   = 1'b1;
                            nxt.wp  = next_slot(cur.wp);
                            nxt.occ = cur.occ + 1'b1;
                            n_total = r_total + 1'b1;
                        end
                    end
                    CMD_REMOVE: begin
                        if (cur.occ != '0) begin
                            en_re    = 1'b1;
                            n_res_rm = 1'b1;
                            nxt.rp   = next_slot(cur.rp);
                            nxt.occ  = cur.occ - 1'b1;
                            n_total  = r_total - 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                st_we          = 1'b1;
                n_st_vld[r_q]  = 1'b1;
                n_res_occ      = nxt.occ;
                n_state        = B_DONE;
            end
            B_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid    = 1'b1;
                    n_out_removed  = r_res_rm ? VALUE_W'(en_rdata) : '0;
                    n_out_vvalid   = r_res_rm;
                    n_out_drop     = r_res_drop;
                    n_out_qitems   = r_res_occ;
                    n_out_qempty   = (r_res_occ == '0);
                    n_out_total    = r_total;
                    n_out_allempty = (r_total == '0);
                    n_state        = B_IDLE;
                end
            end
            B_SW_RD: begin
                st_re    = 1'b1;
                st_raddr = r_idx;
                n_rd_vld = r_st_vld[r_idx];
                n_state  = B_SW_ACC;
            end
            B_SW_ACC: begin
                if (32'(r_idx) + 1 == 32'(i_eff)) begin
                    n_total = sum;
                    n_state = B_IDLE;
                end else begin
                    n_acc   = sum;
                    n_idx   = r_idx + 1'b1;
                    n_state = B_SW_RD;
                end
            end
            default: n_state = B_IDLE;
        endcase

        // New queue count: recompute the total before the next job
        if (i_sweep_start) begin
            n_sweep_pend = 1'b1;
        end
    end

    assign st_wdata = nxt;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_sweep_pend <= 1'b0;
            r_st_vld     <= '0;
            r_rd_vld     <= 1'b0;
            r_idx        <= '0;
            r_acc        <= '0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_pend <= n_sweep_pend;
            r_st_vld     <= n_st_vld;
            r_rd_vld     <= n_rd_vld;
            r_idx        <= n_idx;
            r_acc        <= n_acc;
            r_total      <= n_total;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd          <= n_cmd;
        r_q            <= n_q;
        r_val          <= n_val;
        r_res_occ      <= n_res_occ;
        r_res_rm       <= n_res_rm;
        r_res_drop     <= n_res_drop;
        r_out_removed  <= n_out_removed;
        r_out_vvalid   <= n_out_vvalid;
        r_out_drop     <= n_out_drop;
        r_out_qitems   <= n_out_qitems;
        r_out_qempty   <= n_out_qempty;
        r_out_total    <= n_out_total;
        r_out_allempty <= n_out_allempty;
    end

    assign o_out_valid      = r_out_valid;
    assign o_removed_value  = r_out_removed;
    assign o_value_valid    = r_out_vvalid;
    assign o_insert_dropped = r_out_drop;
    assign o_queue_items    = r_out_qitems;
    assign o_queue_is_empty = r_out_qempty;
    assign o_total_items    = r_out_total;
    assign o_all_are_empty  = r_out_allempty;

endmodule

// File: rtl/per_thread_fifo_bank_unit.sv
// ----------------------------------------------------------------------------
// per_thread_fifo_bank_unit
// Bank of FIFO queues selected by thread id modulo the active queue count.
// ----------------------------------------------------------------------------
// One result comes back for every request. The front end takes a request in,
// reduces the 16-bit thread id modulo the active queue count one 4-bit digit
// per cycle and enqueues a job in a two-entry job queue; it is ready again
// the cycle its job leaves, so it takes no new request while one is in the
// modulo unit, and this modulo unit sets the sustained rate. The back end
// runs each job as a per-queue pointer/count read, then an update plus entry
// memory write or read, then a result load into the output register. A write
// of the active queue count starts a recount of the total that reads each
// active queue's count in turn; requests are still accepted meanwhile and
// run once the recount is done. An insert into a full queue is dropped and
// flagged; a remove from an empty queue returns no value.
module per_thread_fifo_bank_unit #(
    parameter int NUM_QUEUES  = ptfb_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = ptfb_pkg::QUEUE_DEPTH_DEF,
    parameter int DATA_WIDTH  = ptfb_pkg::DATA_WIDTH_DEF
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    // configuration
    input  logic                                                  i_cfg_we,
    input  logic [ptfb_pkg::CFG_W-1:0]                            i_cfg_wdata,
    // request channel
    input  logic                                                  i_in_valid,
    output logic                                                  o_in_stall,
    input  logic [ptfb_pkg::CMD_W-1:0]                            i_command,
    input  logic [ptfb_pkg::THREAD_W-1:0]                         i_thread_id,
    input  logic [ptfb_pkg::VALUE_W-1:0]                          i_item_value,
    // result channel
    output logic                                                  o_out_valid,
    input  logic                                                  i_out_stall,
    output logic [ptfb_pkg::VALUE_W-1:0]                          o_removed_value,
    output logic                                                  o_value_valid,
    output logic                                                  o_insert_dropped,
    output logic [ptfb_pkg::cnt_w(QUEUE_DEPTH)-1:0]               o_queue_items,
    output logic                                                  o_queue_is_empty,
    output logic [ptfb_pkg::cnt_w(NUM_QUEUES*QUEUE_DEPTH)-1:0]    o_total_items,
    output logic                                                  o_all_are_empty
);
    import ptfb_pkg::*;

    localparam int QIW = idx_w(NUM_QUEUES);
    localparam int JW  = CMD_W + QIW + DATA_WIDTH;

    logic [CFG_W-1:0]      r_active;
    logic [CFG_W-1:0]      eff;

    logic                  f_push, jq_full, jq_valid, jq_pop;
    t_cmd                  f_cmd;
    logic [QIW-1:0]        f_q;
    logic [DATA_WIDTH-1:0] f_value;
    logic [JW-1:0]         jq_in, jq_out;

    // Active queue count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    assign eff = eff_count(r_active, NUM_QUEUES);

    // Front end: accept and select queue
    ptfb_front #(
        .NUM_QUEUES (NUM_QUEUES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_thread_id  (i_thread_id),
        .i_item_value (i_item_value),
        .i_eff        (eff),
        .o_push       (f_push),
        .i_full       (jq_full),
        .o_cmd        (f_cmd),
        .o_q          (f_q),
        .o_value      (f_value)
    );

    // Job queue between the two halves
    assign jq_in = {f_cmd, f_q, f_value};

    ptfb_queue #(
        .WIDTH (JW),
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (jq_in),
        .o_full  (jq_full),
        .o_valid (jq_valid),
        .i_pop   (jq_pop),
        .o_data  (jq_out)
    );

    // Back end: execute and report
    ptfb_back #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_eff            (eff),
        .i_sweep_start    (i_cfg_we),
        .i_job_valid      (jq_valid),
        .o_job_pop        (jq_pop),
        .i_job_cmd        (t_cmd'(jq_out[JW-1 -: CMD_W])),
        .i_job_q          (jq_out[DATA_WIDTH +: QIW]),
        .i_job_value      (jq_out[DATA_WIDTH-1:0]),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_removed_value  (o_removed_value),
        .o_value_valid    (o_value_valid),
        .o_insert_dropped (o_insert_dropped),
        .o_queue_items    (o_queue_items),
        .o_queue_is_empty (o_queue_is_empty),
        .o_total_items    (o_total_items),
        .o_all_are_empty  (o_all_are_empty)
    );

endmodule

// File: rtl/ptfb_checker.sv
// ----------------------------------------------------------------------------
// ptfb_checker
// Port-level checks for the FIFO bank, bound to the top level.
// ----------------------------------------------------------------------------
module ptfb_checker #(
    parameter int NUM_QUEUES  = ptfb_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = ptfb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  o_out_valid,
    input  logic                                                  i_out_stall,
    input  logic [ptfb_pkg::VALUE_W-1:0]                          o_removed_value,
    input  logic                                                  o_value_valid,
    input  logic                                                  o_insert_dropped,
    input  logic [ptfb_pkg::cnt_w(QUEUE_DEPTH)-1:0]               o_queue_items,
    input  logic                                                  o_queue_is_empty,
    input  logic [ptfb_pkg::cnt_w(NUM_QUEUES*QUEUE_DEPTH)-1:0]    o_total_items,
    input  logic                                                  o_all_are_empty
);
    import ptfb_pkg::*;

    localparam int TW = cnt_w(NUM_QUEUES * QUEUE_DEPTH);

    // A stalled result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_removed_value) && $stable(o_queue_items)
            && $stable(o_total_items))
        else $error("result changed while stalled");

    // Queue empty flag agrees with its count
    a_q_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_queue_is_empty == (o_queue_items == '0)))
        else $error("queue empty flag mismatch");

    // All-empty flag agrees with the total
    a_all_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_all_are_empty == (o_total_items == '0)))
        else $error("all-empty flag mismatch");

    // Selected queue is part of the total
    a_q_in_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (TW'(o_queue_items) <= o_total_items))
        else $error("queue count exceeds total");

    // Removed value only with a remove, never with a drop
    a_remove_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_value_valid && o_insert_dropped)
                        && (o_value_valid || (o_removed_value == '0)))
        else $error("remove/drop flags inconsistent");

endmodule

bind per_thread_fifo_bank_unit ptfb_checker #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_ptfb_checker (.*);

// File: tb/fifo_bank_checker.sv
// ----------------------------------------------------------------------------
// fifo_bank_checker
// Watches both channels of the per-thread FIFO bank and checks every result.
// ----------------------------------------------------------------------------
// Keeps its own copy of the queue bank and of the active queue count. Each
// request transaction accepted on the input side is applied to that copy, and
// the expected result is queued. Each result transaction is compared field by
// field with the oldest queued result. Counters go back to the testbench top.
module fifo_bank_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ptfb_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [ptfb_pkg::CMD_W-1:0]      i_command,
    input  logic [ptfb_pkg::THREAD_W-1:0]   i_thread_id,
    input  logic [ptfb_pkg::VALUE_W-1:0]    i_item_value,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [ptfb_pkg::VALUE_W-1:0]    i_removed_value,
    input  logic                            i_value_valid,
    input  logic                            i_insert_dropped,
    input  logic [6:0]                      i_queue_items,
    input  logic                            i_queue_is_empty,
    input  logic [9:0]                      i_total_items,
    input  logic                            i_all_are_empty,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked,
    output int                              o_drops,
    output int                              o_empty_removes
);
    timeunit 1ns;
    timeprecision 1ps;

    import ptfb_pkg::*;

    localparam int NQ      = NUM_QUEUES_DEF;
    localparam int DEPTH   = QUEUE_DEPTH_DEF;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int QCNT_W  = $clog2(DEPTH + 1);
    localparam int TOTAL_W = $clog2(NQ * DEPTH + 1);
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [VALUE_W-1:0] removed_value;
        logic               value_valid;
        logic               insert_dropped;
        logic [QCNT_W-1:0]  queue_items;
        logic               queue_is_empty;
        logic [TOTAL_W-1:0] total_items;
        logic               all_are_empty;
    } t_bank_result;

    // Mirror of the bank
    logic [VALUE_W-1:0] entry_store [NQ*DEPTH];
    logic [PTR_W-1:0]   head_ptr    [NQ];
    logic [PTR_W-1:0]   tail_ptr    [NQ];
    int unsigned        fill_level  [NQ];
    logic [CFG_W-1:0]   active_setting;

    t_bank_result expected_results [$];
    int fail_count    = 0;
    int checked_count = 0;
    int drop_count    = 0;
    int empty_removes = 0;

    // Apply one request to the mirror and return the result it must produce
    function automatic t_bank_result apply_request(input t_cmd cmd,
                                                   input logic [THREAD_W-1:0] tid,
                                                   input logic [VALUE_W-1:0] value);
        int unsigned  used;
        int unsigned  q;
        int unsigned  slot;
        int unsigned  sum;
        int           i;
        t_bank_result r;
        // zero acts as one queue, large settings clip to the bank size
        if (active_setting == '0) begin
            used = 1;
        end else if (int'(active_setting) > NQ) begin
            used = NQ;
        end else begin
            used = active_setting;
        end
        q = tid % used;
        r = '0;
        case (cmd)
            CMD_INSERT: begin
                if (fill_level[q] >= DEPTH) begin
                    r.insert_dropped = 1'b1;
                end else begin
                    slot = q * DEPTH + tail_ptr[q];
                    entry_store[slot] = value;
                    tail_ptr[q] = (tail_ptr[q] == PTR_W'(DEPTH - 1)) ? '0
                                                                    : tail_ptr[q] + 1'b1;
                    fill_level[q]++;
                end
            end
            CMD_REMOVE: begin
                if (fill_level[q] != 0) begin
                    slot = q * DEPTH + head_ptr[q];
                    r.removed_value = entry_store[slot];
                    r.value_valid = 1'b1;
                    head_ptr[q] = (head_ptr[q] == PTR_W'(DEPTH - 1)) ? '0
                                                                    : head_ptr[q] + 1'b1;
                    fill_level[q]--;
                end
            end
            default: begin
            end
        endcase
        // only active queues count toward the total
        sum = 0;
        for (i = 0; i < int'(used); i++) begin
            sum += fill_level[i];
        end
        r.queue_items    = QCNT_W'(fill_level[q]);
        r.queue_is_empty = (fill_level[q] == 0);
        r.total_items    = TOTAL_W'(sum);
        r.all_are_empty  = (sum == 0);
        return r;
    endfunction

    // Observe, predict and compare
    always @(posedge i_clk) begin
        t_bank_result want;
        t_bank_result got;
        int           i;
        if (!i_rst_n) begin
            for (i = 0; i < NQ; i++) begin
                head_ptr[i]   = '0;
                tail_ptr[i]   = '0;
                fill_level[i] = 0;
            end
            active_setting = ACTIVE_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                active_setting = i_cfg_wdata;
            end
            // result side first, so a stray result never meets a fresh request
            if (i_out_valid && !i_out_stall) begin
                got.removed_value  = i_removed_value;
                got.value_valid    = i_value_valid;
                got.insert_dropped = i_insert_dropped;
                got.queue_items    = i_queue_items;
                got.queue_is_empty = i_queue_is_empty;
                got.total_items    = i_total_items;
                got.all_are_empty  = i_all_are_empty;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("[%0t] result with no request outstanding: removed %h", $realtime,
                                 i_removed_value);
                    end
                end else begin
                    want = expected_results.pop_front();
                    checked_count++;
                    if (got.removed_value  !== want.removed_value  ||
                        got.value_valid    !== want.value_valid    ||
                        got.insert_dropped !== want.insert_dropped ||
                        got.queue_items    !== want.queue_items    ||
                        got.queue_is_empty !== want.queue_is_empty ||
                        got.total_items    !== want.total_items    ||
                        got.all_are_empty  !== want.all_are_empty) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("[%0t] result %0d mismatch (expected / actual):",
                                     $realtime, checked_count);
                            $display("  removed %h / %h  valid %b / %b  dropped %b / %b",
                                     want.removed_value, got.removed_value,
                                     want.value_valid, got.value_valid,
                                     want.insert_dropped, got.insert_dropped);
                            $display("  queue %0d / %0d  empty %b / %b  total %0d / %0d"
                                     , want.queue_items, got.queue_items,
                                     want.queue_is_empty, got.queue_is_empty,
                                     want.total_items, got.total_items);
                            $display("  all empty %b / %b",
                                     want.all_are_empty, got.all_are_empty);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = apply_request(t_cmd'(i_command), i_thread_id, i_item_value);
                if (want.insert_dropped) begin
                    drop_count++;
                end
                if (t_cmd'(i_command) == CMD_REMOVE && !want.value_valid) begin
                    empty_removes++;
                end
                expected_results.push_back(want);
            end
        end
        o_pending       <= expected_results.size();
        o_fail_count    <= fail_count;
        o_checked       <= checked_count;
        o_drops         <= drop_count;
        o_empty_removes <= empty_removes;
    end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the per-thread FIFO bank unit.
// ----------------------------------------------------------------------------
// A directed opener covers empty queues, field extremes and every command.
// Random phases follow, each under its own active queue count (zero, the
// reset value, one, mid values and out-of-range), with phases that fill a
// queue until inserts drop, phases that drain until removes find nothing,
// and varied sender idling and receiver stalls, including long hold-offs.
// All checking lives in fifo_bank_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ptfb_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_cfg_we         = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wdata      = '0;
    logic                i_in_valid       = 1'b0;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_command        = '0;
    logic [THREAD_W-1:0] i_thread_id      = '0;
    logic [VALUE_W-1:0]  i_item_value     = '0;
    logic                o_out_valid;
    logic                i_out_stall      = 1'b0;
    logic [VALUE_W-1:0]  o_removed_value;
    logic                o_value_valid;
    logic                o_insert_dropped;
    logic [6:0]          o_queue_items;
    logic                o_queue_is_empty;
    logic [9:0]          o_total_items;
    logic                o_all_are_empty;

    int fail_count;
    int pending;
    int checked;
    int drops;
    int empty_removes;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_reqs   = 0;
    int holds_done  = 0;
    int hold_left   = 0;
    int quiet_cycles = 0;
    int requests_sent = 0;

    always #2 i_clk = ~i_clk;

    per_thread_fifo_bank_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_thread_id      (i_thread_id),
        .i_item_value     (i_item_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_removed_value  (o_removed_value),
        .o_value_valid    (o_value_valid),
        .o_insert_dropped (o_insert_dropped),
        .o_queue_items    (o_queue_items),
        .o_queue_is_empty (o_queue_is_empty),
        .o_total_items    (o_total_items),
        .o_all_are_empty  (o_all_are_empty)
    );

    fifo_bank_checker u_bank_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_thread_id      (i_thread_id),
        .i_item_value     (i_item_value),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_removed_value  (o_removed_value),
        .i_value_valid    (o_value_valid),
        .i_insert_dropped (o_insert_dropped),
        .i_queue_items    (o_queue_items),
        .i_queue_is_empty (o_queue_is_empty),
        .i_total_items    (o_total_items),
        .i_all_are_empty  (o_all_are_empty),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_drops          (drops),
        .o_empty_removes  (empty_removes)
    );

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_reqs != holds_done) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= hold_reqs;
        end
        i_out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end

    // Watchdog: too long with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("per_thread_fifo_bank_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request and hold it until accepted
    task automatic send_request(input t_cmd cmd, input logic [THREAD_W-1:0] tid,
                                input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_thread_id  <= tid;
        i_item_value <= value;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        requests_sent++;
    endtask

    // Change the active queue count once every result is back
    task automatic write_active(input logic [CFG_W-1:0] count);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One random phase under a given active count and traffic mix
    task automatic run_phase(input logic [CFG_W-1:0] count, input int n_req,
                             input int idle, input int stall, input int ins_pct,
                             input int rem_pct, input bit with_hold);
        int                  k;
        int                  roll;
        t_cmd                cmd;
        logic [THREAD_W-1:0] tid;
        write_active(count);
        idle_pct = idle;
        stall_pct <= stall;
        for (k = 0; k < n_req; k++) begin
            if (with_hold && k == n_req / 4) begin
                hold_reqs <= hold_reqs + 1;
            end
            roll = $urandom_range(99);
            if (roll < ins_pct) begin
                cmd = CMD_INSERT;
            end else if (roll < ins_pct + rem_pct) begin
                cmd = CMD_REMOVE;
            end else if ($urandom_range(1) == 0) begin
                cmd = CMD_QUERY_Q;
            end else begin
                cmd = CMD_QUERY_ALL;
            end
            // occasional extreme thread ids, otherwise anything
            case ($urandom_range(15))
                0:       tid = '0;
                1:       tid = '1;
                default: tid = THREAD_W'($urandom());
            endcase
            send_request(cmd, tid, $urandom());
        end
    endtask

    // Main sequence
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty bank, value extremes, every command, wraparound ids
        send_request(CMD_QUERY_ALL, 16'd0,     32'h0000_0000);
        send_request(CMD_REMOVE,    16'd0,     32'hFFFF_FFFF);
        send_request(CMD_QUERY_Q,   16'hFFFF,  32'h1234_5678);
        send_request(CMD_INSERT,    16'd0,     32'h0000_0000);
        send_request(CMD_INSERT,    16'hFFFF,  32'hFFFF_FFFF);
        send_request(CMD_INSERT,    16'd8,     32'hA5A5_A5A5);
        send_request(CMD_INSERT,    16'd7,     32'h5A5A_5A5A);
        send_request(CMD_QUERY_Q,   16'd16,    32'hFFFF_FFFF);
        send_request(CMD_QUERY_ALL, 16'h8000,  32'h0000_0001);
        send_request(CMD_REMOVE,    16'd0,     32'h0000_0000);
        send_request(CMD_REMOVE,    16'hFFFF,  32'h0000_0000);
        send_request(CMD_REMOVE,    16'd24,    32'hDEAD_BEEF);
        send_request(CMD_REMOVE,    16'd15,    32'h0000_0000);
        send_request(CMD_REMOVE,    16'd0,     32'h0000_0000);
        send_request(CMD_INSERT,    16'd3,     32'h0000_0001);
        send_request(CMD_INSERT,    16'd4,     32'h8000_0000);
        send_request(CMD_QUERY_ALL, 16'h7FFF,  32'hFFFF_FFFF);

        // Random phases: count, requests, idle %, stall %, insert %, remove %, hold
        run_phase(4'd0,  140,  0,  0, 80, 10, 1'b0);  // single queue until it overflows
        run_phase(4'd15, 140, 85,  0, 40, 40, 1'b0);  // out of range, sparse sender
        run_phase(4'd1,  130,  0, 85, 30, 60, 1'b0);  // slow receiver, draining
        run_phase(4'd3,  140,  8,  8, 50, 35, 1'b1);  // both idle a little, hold-off
        run_phase(4'd8,  150,  0,  0, 25, 65, 1'b0);  // drain into empty removes
        run_phase(4'd5,  130,  0,  0, 45, 45, 1'b1);  // back to back, hold-off

        // Let everything come back, then a short quiet tail
        i_in_valid <= 1'b0;
        stall_pct  <= 0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests under active counts 8, 0, 15, 1, 3, 8 and 5;",
                 requests_sent);
        $display("%0d results checked, %0d inserts refused on full queues,", checked, drops);
        $display("%0d removes on empty queues, %0d hold-offs", empty_removes, hold_reqs);
        if (fail_count == 0 && pending == 0) begin
            $display("per_thread_fifo_bank_unit verification clean");
        end else begin
            $display("per_thread_fifo_bank_unit verification failed");
        end
        $finish;
    end

endmodule
